[design/acm_pkg.sv]
// Shared types and constants for the Aho-Corasick matcher.
// No dependencies; used by acm_ctrl and aho_corasick_matcher.
`default_nettype none
package acm_pkg;

   localparam int MAX_NODES = 1024;
   localparam int ALPHABET  = 26;
   localparam int NODE_W    = 10;                // node index width
   localparam int CNT_W     = 11;                // node count / absent-marked width
   localparam int SYM_W     = 5;                 // symbol width, 32 slots per node
   localparam int GOTO_AW   = NODE_W + SYM_W;    // goto memory address width
   localparam int PAT_W     = 9;                 // pattern id plus "none" bit
   localparam int POS_W     = 16;

   localparam logic [CNT_W-1:0] NODE_ABSENT = CNT_W'(MAX_NODES);
   localparam logic [PAT_W-1:0] NO_PATTERN  = {1'b1, {(PAT_W-1){1'b0}}};

   typedef enum logic [1:0] {
      CMD_INSERT  = 2'd0,
      CMD_BUILD   = 2'd1,
      CMD_SCAN    = 2'd2,
      CMD_RESTART = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_UNBUILT = 2'd2
   } status_type;

   typedef struct packed {
      logic               match_found;
      logic [7:0]         match_id;
      logic [POS_W-1:0]   start_position;
      status_type         status;
   } result_type;

endpackage
`default_nettype wire

[design/acm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module acm_ram #(
   parameter int DATA_W = 8,
   parameter int ADDR_W = 4
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[design/acm_ctrl.sv]
// Sequencer and table memories of the matcher: clear pass, insert, build, scan.
// Depends on acm_pkg and acm_ram.
`default_nettype none
module acm_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   input  wire logic [1:0]               req_command,
   input  wire logic [4:0]               req_symbol,
   input  wire logic                     req_last_symbol,
   input  wire logic [7:0]               req_pattern_id,
   output logic                          req_ready,
   input  wire logic [acm_pkg::POS_W-1:0] pattern_length,
   output logic                          res_valid,
   output acm_pkg::result_type           res,
   input  wire logic                     res_take
);

   typedef enum logic [16:0] {
      ST_CLEAR    = 17'h00001,
      ST_IDLE     = 17'h00002,
      ST_INS_RD   = 17'h00004,
      ST_INS_EV   = 17'h00008,
      ST_BLD_INIT = 17'h00010,
      ST_BLD_POP  = 17'h00020,
      ST_BLD_NODE = 17'h00040,
      ST_BLD_LINK = 17'h00080,
      ST_BLD_EXIT = 17'h00100,
      ST_BLD_CRD1 = 17'h00200,
      ST_BLD_CRD2 = 17'h00400,
      ST_BLD_CWR  = 17'h00800,
      ST_SCN_RD   = 17'h01000,
      ST_SCN_NODE = 17'h02000,
      ST_SCN_PAT  = 17'h04000,
      ST_SCN_EXIT = 17'h08000,
      ST_DONE     = 17'h10000
   } state_type;

   localparam int NW = acm_pkg::NODE_W;
   localparam int CW = acm_pkg::CNT_W;
   localparam int SW = acm_pkg::SYM_W;
   localparam int PW = acm_pkg::PAT_W;
   localparam int QW = acm_pkg::POS_W;
   localparam int AW = acm_pkg::GOTO_AW;

   state_type           state_ff, state_in;
   acm_pkg::cmd_type    cmd_ff, cmd_in;
   logic [SW-1:0]       sym_ff, sym_in;
   logic                last_ff, last_in;
   logic [7:0]          pid_ff, pid_in;
   logic [NW-1:0]       cursor_ff, cursor_in;
   logic [CW-1:0]       node_count_ff, node_count_in;
   logic [NW-1:0]       scan_node_ff, scan_node_in;
   logic [QW-1:0]       text_pos_ff, text_pos_in;
   logic                built_ff, built_in;
   logic [CW-1:0]       head_ff, head_in;
   logic [CW-1:0]       tail_ff, tail_in;
   logic [NW-1:0]       v_ff, v_in;
   logic [NW-1:0]       lk_ff, lk_in;
   logic [SW-1:0]       c_ff, c_in;
   logic [CW-1:0]       child_ff, child_in;
   logic [AW-1:0]       clr_ff, clr_in;
   acm_pkg::result_type res_ff, res_in;

   // memory ports
   logic          goto_we;
   logic [AW-1:0] goto_wa, goto_ra;
   logic [CW-1:0] goto_wd, goto_rd;
   logic          fail_we;
   logic [NW-1:0] fail_wa, fail_wd, fail_ra, fail_rd;
   logic          pat_we;
   logic [NW-1:0] pat_wa, pat_ra;
   logic [PW-1:0] pat_wd, pat_rd;
   logic          exit_we;
   logic [NW-1:0] exit_wa, exit_ra;
   logic [CW-1:0] exit_wd, exit_rd;
   logic          q_we;
   logic [NW-1:0] q_wa, q_wd, q_ra, q_rd;

   // combinational helpers
   logic          full;
   logic [NW-1:0] nxt;
   logic [NW-1:0] via;
   logic [NW-1:0] sv;

   acm_ram #(.DATA_W(CW), .ADDR_W(AW)) u_goto (
      .clock(clock), .wr_en(goto_we), .wr_addr(goto_wa), .wr_data(goto_wd),
      .rd_addr(goto_ra), .rd_data(goto_rd));
   acm_ram #(.DATA_W(NW), .ADDR_W(NW)) u_fail (
      .clock(clock), .wr_en(fail_we), .wr_addr(fail_wa), .wr_data(fail_wd),
      .rd_addr(fail_ra), .rd_data(fail_rd));
   acm_ram #(.DATA_W(PW), .ADDR_W(NW)) u_pat (
      .clock(clock), .wr_en(pat_we), .wr_addr(pat_wa), .wr_data(pat_wd),
      .rd_addr(pat_ra), .rd_data(pat_rd));
   acm_ram #(.DATA_W(CW), .ADDR_W(NW)) u_exit (
      .clock(clock), .wr_en(exit_we), .wr_addr(exit_wa), .wr_data(exit_wd),
      .rd_addr(exit_ra), .rd_data(exit_rd));
   acm_ram #(.DATA_W(NW), .ADDR_W(NW)) u_queue (
      .clock(clock), .wr_en(q_we), .wr_addr(q_wa), .wr_data(q_wd),
      .rd_addr(q_ra), .rd_data(q_rd));

   assign req_ready = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);
   assign res       = res_ff;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      sym_in        = sym_ff;
      last_in       = last_ff;
      pid_in        = pid_ff;
      cursor_in     = cursor_ff;
      node_count_in = node_count_ff;
      scan_node_in  = scan_node_ff;
      text_pos_in   = text_pos_ff;
      built_in      = built_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      v_in          = v_ff;
      lk_in         = lk_ff;
      c_in          = c_ff;
      child_in      = child_ff;
      clr_in        = clr_ff;
      res_in        = res_ff;

      goto_we = 1'b0; goto_wa = '0; goto_wd = '0; goto_ra = '0;
      fail_we = 1'b0; fail_wa = '0; fail_wd = '0; fail_ra = '0;
      pat_we  = 1'b0; pat_wa  = '0; pat_wd  = '0; pat_ra  = '0;
      exit_we = 1'b0; exit_wa = '0; exit_wd = '0; exit_ra = '0;
      q_we    = 1'b0; q_wa    = '0; q_wd    = '0; q_ra    = '0;

      full = 1'b0;
      nxt  = '0;
      via  = (v_ff == '0) ? '0 : goto_rd[NW-1:0];
      sv   = (sym_ff < SW'(acm_pkg::ALPHABET)) ? goto_rd[NW-1:0] : '0;

      unique case (state_ff)
         // mark every goto and exit entry absent, every node untagged
         ST_CLEAR: begin
            goto_we = 1'b1; goto_wa = clr_ff; goto_wd = acm_pkg::NODE_ABSENT;
            pat_we  = 1'b1; pat_wa  = clr_ff[NW-1:0]; pat_wd = acm_pkg::NO_PATTERN;
            exit_we = 1'b1; exit_wa = clr_ff[NW-1:0]; exit_wd = acm_pkg::NODE_ABSENT;
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == {AW{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_valid) begin
               cmd_in  = acm_pkg::cmd_type'(req_command);
               sym_in  = req_symbol;
               last_in = req_last_symbol;
               pid_in  = req_pattern_id;
               res_in  = '0;
               unique case (acm_pkg::cmd_type'(req_command))
                  acm_pkg::CMD_INSERT: begin
                     if (built_ff) begin
                        res_in.status = acm_pkg::STATUS_FULL;
                        state_in      = ST_DONE;
                     end else if (req_symbol >= SW'(acm_pkg::ALPHABET)) begin
                        state_in = ST_DONE;
                     end else begin
                        state_in = ST_INS_RD;
                     end
                  end
                  acm_pkg::CMD_BUILD: begin
                     state_in = built_ff ? ST_DONE : ST_BLD_INIT;
                  end
                  acm_pkg::CMD_SCAN: begin
                     if (!built_ff) begin
                        res_in.status = acm_pkg::STATUS_UNBUILT;
                        state_in      = ST_DONE;
                     end else begin
                        state_in = ST_SCN_RD;
                     end
                  end
                  acm_pkg::CMD_RESTART: begin
                     scan_node_in = '0;
                     text_pos_in  = '0;
                     state_in     = ST_DONE;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end

         // insert: look up the child, create it if absent
         ST_INS_RD: begin
            goto_ra  = {cursor_ff, sym_ff};
            state_in = ST_INS_EV;
         end

         ST_INS_EV: begin
            if (goto_rd == acm_pkg::NODE_ABSENT) begin
               if (node_count_ff >= CW'(acm_pkg::MAX_NODES)) begin
                  full = 1'b1;
               end else begin
                  goto_we       = 1'b1;
                  goto_wa       = {cursor_ff, sym_ff};
                  goto_wd       = node_count_ff;
                  nxt           = node_count_ff[NW-1:0];
                  node_count_in = node_count_ff + CW'(1);
               end
            end else begin
               nxt = goto_rd[NW-1:0];
            end
            if (!full) begin
               cursor_in = nxt;
            end
            if (last_ff) begin
               if (!full) begin
                  pat_we = 1'b1; pat_wa = nxt; pat_wd = {1'b0, pid_ff};
               end
               cursor_in = '0;
            end
            if (full) begin
               res_in.status = acm_pkg::STATUS_FULL;
            end
            state_in = ST_DONE;
         end

         // build: root goes in the queue with a self link
         ST_BLD_INIT: begin
            fail_we  = 1'b1; fail_wa = '0; fail_wd = '0;
            q_we     = 1'b1; q_wa    = '0; q_wd    = '0;
            head_in  = '0;
            tail_in  = CW'(1);
            state_in = ST_BLD_POP;
         end

         ST_BLD_POP: begin
            if (head_ff == tail_ff) begin
               built_in = 1'b1;
               state_in = ST_DONE;
            end else begin
               q_ra     = head_ff[NW-1:0];
               head_in  = head_ff + CW'(1);
               state_in = ST_BLD_NODE;
            end
         end

         ST_BLD_NODE: begin
            v_in     = q_rd;
            fail_ra  = q_rd;
            state_in = ST_BLD_LINK;
         end

         ST_BLD_LINK: begin
            lk_in    = fail_rd;
            pat_ra   = fail_rd;
            exit_ra  = fail_rd;
            state_in = ST_BLD_EXIT;
         end

         // dictionary exit link of v
         ST_BLD_EXIT: begin
            exit_we = 1'b1;
            exit_wa = v_ff;
            if (v_ff == lk_ff) begin
               exit_wd = acm_pkg::NODE_ABSENT;
            end else if (pat_rd != acm_pkg::NO_PATTERN) begin
               exit_wd = {1'b0, lk_ff};
            end else begin
               exit_wd = exit_rd;
            end
            c_in     = '0;
            state_in = ST_BLD_CRD1;
         end

         ST_BLD_CRD1: begin
            goto_ra  = {v_ff, c_ff};
            state_in = ST_BLD_CRD2;
         end

         ST_BLD_CRD2: begin
            child_in = goto_rd;
            goto_ra  = {lk_ff, c_ff};
            state_in = ST_BLD_CWR;
         end

         // real child: link and enqueue; missing child: fill the goto entry
         ST_BLD_CWR: begin
            if (child_ff != acm_pkg::NODE_ABSENT) begin
               fail_we = 1'b1; fail_wa = child_ff[NW-1:0]; fail_wd = via;
               q_we    = 1'b1; q_wa    = tail_ff[NW-1:0];  q_wd    = child_ff[NW-1:0];
               tail_in = tail_ff + CW'(1);
            end else begin
               goto_we = 1'b1; goto_wa = {v_ff, c_ff}; goto_wd = {1'b0, via};
            end
            if (c_ff == SW'(acm_pkg::ALPHABET - 1)) begin
               state_in = ST_BLD_POP;
            end else begin
               c_in     = c_ff + SW'(1);
               state_in = ST_BLD_CRD1;
            end
         end

         // scan: step, then own pattern, then exit link pattern
         ST_SCN_RD: begin
            goto_ra  = {scan_node_ff, sym_ff};
            state_in = ST_SCN_NODE;
         end

         ST_SCN_NODE: begin
            scan_node_in = sv;
            pat_ra       = sv;
            exit_ra      = sv;
            state_in     = ST_SCN_PAT;
         end

         ST_SCN_PAT: begin
            if (pat_rd != acm_pkg::NO_PATTERN) begin
               res_in.match_found    = 1'b1;
               res_in.match_id       = pat_rd[7:0];
               res_in.start_position = text_pos_ff - pattern_length + QW'(1);
               text_pos_in           = text_pos_ff + QW'(1);
               state_in              = ST_DONE;
            end else if (exit_rd != acm_pkg::NODE_ABSENT) begin
               pat_ra   = exit_rd[NW-1:0];
               state_in = ST_SCN_EXIT;
            end else begin
               text_pos_in = text_pos_ff + QW'(1);
               state_in    = ST_DONE;
            end
         end

         ST_SCN_EXIT: begin
            res_in.match_found    = 1'b1;
            res_in.match_id       = pat_rd[7:0];
            res_in.start_position = text_pos_ff - pattern_length + QW'(1);
            text_pos_in           = text_pos_ff + QW'(1);
            state_in              = ST_DONE;
         end

         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         node_count_ff <= CW'(1);
         cursor_ff     <= '0;
         scan_node_ff  <= '0;
         text_pos_ff   <= '0;
         built_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         node_count_ff <= node_count_in;
         cursor_ff     <= cursor_in;
         scan_node_ff  <= scan_node_in;
         text_pos_ff   <= text_pos_in;
         built_ff      <= built_in;
      end
   end

   // payload and work registers
   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      sym_ff   <= sym_in;
      last_ff  <= last_in;
      pid_ff   <= pid_in;
      head_ff  <= head_in;
      tail_ff  <= tail_in;
      v_ff     <= v_in;
      lk_ff    <= lk_in;
      c_ff     <= c_in;
      child_ff <= child_in;
      res_ff   <= res_in;
   end

endmodule
`default_nettype wire

[design/aho_corasick_matcher.sv]
// Top level of the Aho-Corasick matcher: register port, result register.
// Depends on acm_pkg and acm_ctrl.
`default_nettype none
// Multi-pattern matcher over the letters a..z, one transaction per item, one
// result per item. After reset a clearing pass walks all 32768 goto memory
// entries, one entry a cycle, before the first transaction is taken. An insert
// reads the goto entry and then evaluates it (dropped at once after the build
// or for a symbol outside a..z); a scan chains the goto, pattern and exit-link
// memory reads (answered at once before the build). A build sweeps all 26
// letters of each trie node through the goto memory, with two reads per letter
// and a goto write for each missing child. A finished result sits in the
// output register while the next transaction is already being worked on.
module aho_corasick_matcher (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_command,
   input  wire logic [4:0]  req_symbol,
   input  wire logic        req_last_symbol,
   input  wire logic [7:0]  req_pattern_id,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_match_found,
   output logic [7:0]       rsp_match_id,
   output logic [15:0]      rsp_start_position,
   output logic [1:0]       rsp_status,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic                          req_ready;
   logic                          res_valid;
   logic                          res_take;
   acm_pkg::result_type           res;
   logic [acm_pkg::POS_W-1:0]     len_ff, len_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   acm_pkg::result_type           rsp_ff, rsp_in;

   assign req_stall = !req_ready;

   acm_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_command(req_command), .req_symbol(req_symbol),
      .req_last_symbol(req_last_symbol), .req_pattern_id(req_pattern_id),
      .req_ready(req_ready), .pattern_length(len_ff),
      .res_valid(res_valid), .res(res), .res_take(res_take));

   // register port: pattern_length at offset 0
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr[2] ? 32'd0 : {16'd0, len_ff};
   always_comb begin
      len_in = len_ff;
      if (csr_psel && csr_penable && csr_pwrite && !csr_paddr[2]) begin
         len_in = csr_pwdata[acm_pkg::POS_W-1:0];
      end
   end

   // result register: loads when empty or being drained
   assign res_take = res_valid && (!rsp_valid_ff || !rsp_stall);
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= acm_pkg::POS_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_match_found    = rsp_ff.match_found;
   assign rsp_match_id       = rsp_ff.match_id;
   assign rsp_start_position = rsp_ff.start_position;
   assign rsp_status         = rsp_ff.status;

endmodule
`default_nettype wire
